/* rtl/core/hbs_pkg.sv */
// ----------------------------------------------------------------------------
// hbs_pkg
// shared constants for the heightmap bilinear sampler
// ----------------------------------------------------------------------------
package hbs_pkg;

    localparam int MAX_GRID_WIDTH  = 256;
    localparam int MAX_GRID_HEIGHT = 256;
    localparam int STORE_DEPTH     = 65536;
    localparam int ADDR_W          = 16;
    localparam int HEIGHT_W        = 32;
    localparam int SIZE_W          = 9;
    localparam int IDX_W           = 8;
    localparam int FRAC_W          = 8;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;
    localparam int IN_DATA_W       = 112;
    localparam int OUT_DATA_W      = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_EDGE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_EDGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_X_SCALE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE     = 3'd5;

    // operation codes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

endpackage

/* rtl/core/hbs_ram.sv */
// ----------------------------------------------------------------------------
// hbs_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module hbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/heightmap_bilinear_sampler.sv */
// ----------------------------------------------------------------------------
// heightmap_bilinear_sampler
// bilinear height lookup over a row-major grid with clamp-to-edge addressing
// ----------------------------------------------------------------------------
// Takes one word per clock unless stalled and returns one word per word
// taken, in order. A word with tuser 0 writes one height into the grid
// store and is answered by an acknowledge; tuser 1 samples a world position.
// The stages from acceptance to the result register are edge subtract,
// 32x32 scale multiply, cell split and clamp, address build, store read,
// column blend, row blend, rounding. The four neighbours are read in the
// same clock from four copies of the 64K-word store, each written by every
// write word, so the throughput is one word per clock whenever the output is
// taken. The whole pipeline holds while a finished result waits unaccepted.
// ----------------------------------------------------------------------------
module heightmap_bilinear_sampler (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [hbs_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [hbs_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // write_address[15:0], write_height[47:16], query_x[79:48], query_y[111:80]
    input  logic [hbs_pkg::IN_DATA_W-1:0]         s_axis_tdata,
    // operation
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // height[31:0]
    output logic [hbs_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // was_write
    output logic                                  m_axis_tuser
);

    localparam int HW = hbs_pkg::HEIGHT_W;
    localparam int AW = hbs_pkg::ADDR_W;
    localparam int IW = hbs_pkg::IDX_W;
    localparam int FW = hbs_pkg::FRAC_W;
    localparam int SW = hbs_pkg::SIZE_W;
    localparam int ROW_W = HW + FW + 2;
    localparam int SUM_W = ROW_W + FW + 2;

    // configuration
    logic [SW-1:0] r_grid_width, r_grid_height;
    logic [HW-1:0] r_left_edge, r_bottom_edge, r_x_scale, r_y_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= SW'(hbs_pkg::MAX_GRID_WIDTH);
            r_grid_height <= SW'(hbs_pkg::MAX_GRID_HEIGHT);
            r_left_edge   <= '0;
            r_bottom_edge <= '0;
            r_x_scale     <= 32'h0100_0000;
            r_y_scale     <= 32'h0100_0000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                hbs_pkg::REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[SW-1:0];
                hbs_pkg::REG_GRID_HEIGHT: r_grid_height <= i_cfg_data[SW-1:0];
                hbs_pkg::REG_LEFT_EDGE:   r_left_edge   <= i_cfg_data;
                hbs_pkg::REG_BOTTOM_EDGE: r_bottom_edge <= i_cfg_data;
                hbs_pkg::REG_X_SCALE:     r_x_scale     <= i_cfg_data;
                hbs_pkg::REG_Y_SCALE:     r_y_scale     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective grid sizes and last index
    logic [SW-1:0] w_width, w_height;
    logic [IW-1:0] w_wm1, w_hm1;

    always_comb begin
        if (r_grid_width == '0) begin
            w_width = SW'(1);
        end else if (r_grid_width > SW'(hbs_pkg::MAX_GRID_WIDTH)) begin
            w_width = SW'(hbs_pkg::MAX_GRID_WIDTH);
        end else begin
            w_width = r_grid_width;
        end
        if (r_grid_height == '0) begin
            w_height = SW'(1);
        end else if (r_grid_height > SW'(hbs_pkg::MAX_GRID_HEIGHT)) begin
            w_height = SW'(hbs_pkg::MAX_GRID_HEIGHT);
        end else begin
            w_height = r_grid_height;
        end
    end

    logic [SW-1:0] w_wm1_full, w_hm1_full;
    assign w_wm1_full = w_width - SW'(1);
    assign w_hm1_full = w_height - SW'(1);
    assign w_wm1 = w_wm1_full[IW-1:0];
    assign w_hm1 = w_hm1_full[IW-1:0];

    // pipeline advance
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic w_adv;
    assign w_adv = !r_v8 || m_axis_tready;
    assign s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_v5 <= 1'b0; r_v6 <= 1'b0; r_v7 <= 1'b0; r_v8 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= s_axis_tvalid;
            r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3;
            r_v5 <= r_v4; r_v6 <= r_v5; r_v7 <= r_v6; r_v8 <= r_v7;
        end
    end

    // stage 1: edge subtract
    logic [AW-1:0] w_in_addr;
    logic [HW-1:0] w_in_height, w_in_qx, w_in_qy;
    assign w_in_addr   = s_axis_tdata[15:0];
    assign w_in_height = s_axis_tdata[47:16];
    assign w_in_qx     = s_axis_tdata[79:48];
    assign w_in_qy     = s_axis_tdata[111:80];

    logic          r_s1_op;
    logic [AW-1:0] r_s1_addr;
    logic [HW-1:0] r_s1_wdata;
    logic [HW:0]   r_s1_dx, r_s1_dy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_op    <= s_axis_tuser;
            r_s1_addr  <= w_in_addr;
            r_s1_wdata <= w_in_height;
            r_s1_dx    <= {w_in_qx[HW-1], w_in_qx} - {r_left_edge[HW-1], r_left_edge};
            r_s1_dy    <= {w_in_qy[HW-1], w_in_qy} - {r_bottom_edge[HW-1], r_bottom_edge};
        end
    end

    // stage 2: scale multiply
    logic            r_s2_op, r_s2_negx, r_s2_negy;
    logic [AW-1:0]   r_s2_addr;
    logic [HW-1:0]   r_s2_wdata;
    logic [2*HW-1:0] r_s2_px, r_s2_py;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_op    <= r_s1_op;
            r_s2_addr  <= r_s1_addr;
            r_s2_wdata <= r_s1_wdata;
            r_s2_negx  <= r_s1_dx[HW];
            r_s2_negy  <= r_s1_dy[HW];
            r_s2_px    <= r_s1_dx[HW-1:0] * r_x_scale;
            r_s2_py    <= r_s1_dy[HW-1:0] * r_y_scale;
        end
    end

    // stage 3: cell split and clamp; cell sits above the 24+8 fraction bits
    logic [HW-1:0] w_cx, w_cy;
    logic [FW-1:0] w_fx, w_fy;
    assign w_cx = r_s2_negx ? '0 : r_s2_px[2*HW-1:HW];
    assign w_cy = r_s2_negy ? '0 : r_s2_py[2*HW-1:HW];
    assign w_fx = r_s2_negx ? '0 : r_s2_px[HW-1:HW-FW];
    assign w_fy = r_s2_negy ? '0 : r_s2_py[HW-1:HW-FW];

    logic          r_s3_op;
    logic [AW-1:0] r_s3_addr;
    logic [HW-1:0] r_s3_wdata;
    logic [IW-1:0] r_s3_x0, r_s3_x1, r_s3_y0, r_s3_y1;
    logic [FW-1:0] r_s3_fx, r_s3_fy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_op    <= r_s2_op;
            r_s3_addr  <= r_s2_addr;
            r_s3_wdata <= r_s2_wdata;
            r_s3_fx    <= w_fx;
            r_s3_fy    <= w_fy;
            if (w_cx < HW'(w_wm1)) begin
                r_s3_x0 <= w_cx[IW-1:0];
                r_s3_x1 <= w_cx[IW-1:0] + IW'(1);
            end else begin
                r_s3_x0 <= w_wm1;
                r_s3_x1 <= w_wm1;
            end
            if (w_cy < HW'(w_hm1)) begin
                r_s3_y0 <= w_cy[IW-1:0];
                r_s3_y1 <= w_cy[IW-1:0] + IW'(1);
            end else begin
                r_s3_y0 <= w_hm1;
                r_s3_y1 <= w_hm1;
            end
        end
    end

    // stage 4: row-major addresses; index 0..3 = (x0,y0) (x1,y0) (x0,y1) (x1,y1)
    logic [IW+SW-1:0] w_b0, w_b1;
    assign w_b0 = r_s3_y0 * w_width;
    assign w_b1 = r_s3_y1 * w_width;

    logic          r_s4_op;
    logic [HW-1:0] r_s4_wdata;
    logic [AW-1:0] r_s4_waddr;
    logic [AW-1:0] r_s4_raddr [4];
    logic [FW-1:0] r_s4_fx, r_s4_fy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_op       <= r_s3_op;
            r_s4_wdata    <= r_s3_wdata;
            r_s4_waddr    <= r_s3_addr;
            r_s4_fx       <= r_s3_fx;
            r_s4_fy       <= r_s3_fy;
            r_s4_raddr[0] <= AW'(w_b0 + (IW+SW)'(r_s3_x0));
            r_s4_raddr[1] <= AW'(w_b0 + (IW+SW)'(r_s3_x1));
            r_s4_raddr[2] <= AW'(w_b1 + (IW+SW)'(r_s3_x0));
            r_s4_raddr[3] <= AW'(w_b1 + (IW+SW)'(r_s3_x1));
        end
    end

    // stage 5: store access, every copy takes every write
    logic          w_we;
    logic [HW-1:0] w_rd [4];
    assign w_we = w_adv && r_v4 && (r_s4_op == hbs_pkg::OP_WRITE);

    for (genvar g = 0; g < 4; g++) begin : g_bank
        hbs_ram #(
            .WIDTH (hbs_pkg::HEIGHT_W),
            .DEPTH (hbs_pkg::STORE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we),
            .i_waddr (r_s4_waddr),
            .i_wdata (r_s4_wdata),
            .i_re    (w_adv),
            .i_raddr (r_s4_raddr[g]),
            .o_rdata (w_rd[g])
        );
    end

    logic          r_s5_op;
    logic [FW-1:0] r_s5_fx, r_s5_fy;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_op <= r_s4_op;
            r_s5_fx <= r_s4_fx;
            r_s5_fy <= r_s4_fy;
        end
    end

    // stage 6: column blend
    logic signed [FW+1:0] w_wx_lo, w_wx_hi;
    assign w_wx_hi = $signed({2'b00, r_s5_fx});
    assign w_wx_lo = $signed(10'd256) - w_wx_hi;

    logic                    r_s6_op;
    logic [FW-1:0]           r_s6_fy;
    logic signed [ROW_W-1:0] r_s6_row0, r_s6_row1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s6_op   <= r_s5_op;
            r_s6_fy   <= r_s5_fy;
            r_s6_row0 <= $signed(w_rd[0]) * w_wx_lo + $signed(w_rd[1]) * w_wx_hi;
            r_s6_row1 <= $signed(w_rd[2]) * w_wx_lo + $signed(w_rd[3]) * w_wx_hi;
        end
    end

    // stage 7: row blend
    logic signed [FW+1:0] w_wy_lo, w_wy_hi;
    assign w_wy_hi = $signed({2'b00, r_s6_fy});
    assign w_wy_lo = $signed(10'd256) - w_wy_hi;

    logic                    r_s7_op;
    logic signed [SUM_W-1:0] r_s7_sum;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s7_op  <= r_s6_op;
            r_s7_sum <= r_s6_row0 * w_wy_lo + r_s6_row1 * w_wy_hi;
        end
    end

    // stage 8: round to nearest, ties up
    logic signed [SUM_W-1:0] w_rnd;
    assign w_rnd = (r_s7_sum + SUM_W'(32768)) >>> 16;

    logic          r_s8_op;
    logic [HW-1:0] r_s8_height;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s8_op     <= r_s7_op;
            r_s8_height <= (r_s7_op == hbs_pkg::OP_WRITE) ? '0 : w_rnd[HW-1:0];
        end
    end

    assign m_axis_tvalid = r_v8;
    assign m_axis_tdata  = r_s8_height;
    assign m_axis_tuser  = (r_s8_op == hbs_pkg::OP_WRITE);

endmodule
